// File: rtl/crcgc_pkg.sv
`timescale 1ns / 1ps

package crcgc_pkg;

   localparam int MAX_DEGREE = 32;

   localparam int RemW    = MAX_DEGREE;
   localparam int TopW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int DegW    = 6;
   localparam int PolyW   = 32;
   localparam int RspRemW = 32;
   localparam int CsrW    = 32;

   localparam logic [PolyW-1:0] PolyReset   = PolyW'(7);
   localparam logic [DegW-1:0]  DegreeReset = DegW'(3);

   typedef enum logic [0:0] {
      CSR_POLY_LOW_BITS = 1'b0,
      CSR_POLY_DEGREE   = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_GENERATE = 1'b0,
      MODE_CHECK    = 1'b1
   } mode_type;

   typedef struct packed {
      logic [RemW-1:0] poly;
      logic [RemW-1:0] mask;
      logic [TopW-1:0] top_idx;
   } crc_cfg_type;

endpackage

// File: rtl/crcgc_req_if.sv
`timescale 1ns / 1ps

interface crcgc_req_if;
   logic valid;
   logic ready;
   logic data_bit;
   logic last;
   logic mode;

   modport source (output valid, output data_bit, output last, output mode, input ready);
   modport sink   (input valid, input data_bit, input last, input mode, output ready);
endinterface

// File: rtl/crcgc_rsp_if.sv
`timescale 1ns / 1ps

interface crcgc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [crcgc_pkg::RspRemW-1:0]  remainder;
   logic                           remainder_zero;

   modport source (output valid, output remainder, output remainder_zero, input ready);
   modport sink   (input valid, input remainder, input remainder_zero, output ready);
endinterface

// File: rtl/crcgc_cfg.sv
`timescale 1ns / 1ps

module crcgc_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  crcgc_pkg::csr_index_type       csr_index,
   input  logic [crcgc_pkg::CsrW-1:0]     csr_write_data,
   output crcgc_pkg::crc_cfg_type         cfg
);

   logic [crcgc_pkg::PolyW-1:0] poly_ff, poly_in;
   logic [crcgc_pkg::DegW-1:0]  degree_ff, degree_in;
   logic [crcgc_pkg::RemW-1:0]  mask;
   logic [crcgc_pkg::RemW-1:0]  poly_ext;
   int                          deg_eff;

   always_comb begin
      poly_in   = poly_ff;
      degree_in = degree_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            crcgc_pkg::CSR_POLY_LOW_BITS: poly_in   = crcgc_pkg::PolyW'(csr_write_data);
            crcgc_pkg::CSR_POLY_DEGREE:   degree_in = crcgc_pkg::DegW'(csr_write_data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff   <= crcgc_pkg::PolyReset;
         degree_ff <= crcgc_pkg::DegreeReset;
      end else begin
         poly_ff   <= poly_in;
         degree_ff <= degree_in;
      end
   end

   // degree 0 acts as 1, anything above the maximum is clamped
   always_comb begin
      deg_eff = int'(degree_ff);
      if (deg_eff < 1) begin
         deg_eff = 1;
      end
      if (deg_eff > crcgc_pkg::MAX_DEGREE) begin
         deg_eff = crcgc_pkg::MAX_DEGREE;
      end
      for (int i = 0; i < crcgc_pkg::RemW; i++) begin
         mask[i] = (i < deg_eff);
      end
      poly_ext    = crcgc_pkg::RemW'(poly_ff);
      cfg.mask    = mask;
      cfg.poly    = poly_ext & mask;
      cfg.top_idx = crcgc_pkg::TopW'(deg_eff - 1);
   end

endmodule

// File: rtl/crcgc_core.sv
`timescale 1ns / 1ps

module crcgc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  crcgc_pkg::crc_cfg_type cfg,
   crcgc_req_if.sink              req_chan,
   crcgc_rsp_if.source            rsp_chan
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_bit_ff, in_bit_in;
   logic                          in_last_ff, in_last_in;
   crcgc_pkg::mode_type           in_mode_ff, in_mode_in;
   logic [crcgc_pkg::RemW-1:0]    rem_ff, rem_in;
   logic                          out_valid_ff, out_valid_in;
   logic [crcgc_pkg::RemW-1:0]    out_rem_ff, out_rem_in;
   logic                          out_zero_ff, out_zero_in;

   logic                          advance;
   logic                          accept;
   logic [crcgc_pkg::RemW-1:0]    r_cur;
   logic [crcgc_pkg::RemW-1:0]    r_shift;
   logic [crcgc_pkg::RemW-1:0]    r_next;
   logic                          top;
   logic                          feedback;

   assign advance        = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // one shift and masked xor per word
   always_comb begin
      r_cur = rem_ff & cfg.mask;
      top   = r_cur[cfg.top_idx];
      if (in_mode_ff == crcgc_pkg::MODE_CHECK) begin
         r_shift  = {r_cur[crcgc_pkg::RemW-2:0], in_bit_ff} & cfg.mask;
         feedback = top;
      end else begin
         r_shift  = {r_cur[crcgc_pkg::RemW-2:0], 1'b0} & cfg.mask;
         feedback = top ^ in_bit_ff;
      end
      r_next = feedback ? (r_shift ^ cfg.poly) : r_shift;
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_bit_in    = in_bit_ff;
      in_last_in   = in_last_ff;
      in_mode_in   = in_mode_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      out_rem_in   = out_rem_ff;
      out_zero_in  = out_zero_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            rem_in       = '0;
            out_valid_in = 1'b1;
            out_rem_in   = r_next;
            out_zero_in  = (r_next == '0);
         end else begin
            rem_in = r_next;
         end
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_bit_in   = req_chan.data_bit;
         in_last_in  = req_chan.last;
         in_mode_in  = crcgc_pkg::mode_type'(req_chan.mode);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      in_bit_ff   <= in_bit_in;
      in_last_ff  <= in_last_in;
      in_mode_ff  <= in_mode_in;
      out_rem_ff  <= out_rem_in;
      out_zero_ff <= out_zero_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.remainder      = crcgc_pkg::RspRemW'(out_rem_ff);
   assign rsp_chan.remainder_zero = out_zero_ff;

   a_rem_cleared_after_last: assert property (
      @(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (rem_ff == '0))
      else $error("running remainder not cleared after last word");

   a_rsp_from_last: assert property (
      @(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result raised without a last word");

   a_zero_flag: assert property (
      @(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_zero_ff == (out_rem_ff == '0)))
      else $error("zero flag disagrees with remainder");

   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready && in_valid_ff && in_last_ff) |=> $stable(out_rem_ff))
      else $error("pending result overwritten");

endmodule

// File: rtl/crc_generate_and_check.sv
// Bit-serial CRC generator and checker with a configurable generator polynomial.
// Datapath: each accepted word is held in the input register; a last word's result is registered.
// Throughput: 1 bit per cycle, one masked shift/xor; a pending result can hold a last bit.
// Reset: synchronous, active high; clears the running remainder and sets generator 7, degree 3.
`timescale 1ns / 1ps

module crc_generate_and_check (
   input  logic                        clock,
   input  logic                        reset,
   crcgc_req_if.sink                   req_chan,
   crcgc_rsp_if.source                 rsp_chan,
   input  logic                        csr_write_enable,
   input  crcgc_pkg::csr_index_type    csr_index,
   input  logic [crcgc_pkg::CsrW-1:0]  csr_write_data
);

   crcgc_pkg::crc_cfg_type cfg;

   crcgc_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   crcgc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
